// ----- rtl/core/parp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// parp_pkg
// Shared types and constants for the proxy ARP route table.
// ----------------------------------------------------------------------------
package parp_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam logic [15:0] TIMEOUT_RESET = 16'd60;
    localparam logic [5:0] CNT_MAX = 6'd63;

    // operation codes
    typedef enum logic [2:0] {
        OP_REFRESH = 3'd0,
        OP_FIND    = 3'd1,
        OP_MARK    = 3'd2,
        OP_AGE     = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_COUNT   = 3'd5
    } t_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_COMPACT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] ip_address;
        logic [1:0]  interface_id;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [1:0] route_interface;
        logic [5:0] entry_count;
        logic       status;
    } t_rsp;

    // one table entry as held in a cell
    typedef struct packed {
        logic        valid;
        logic        wanted;
        logic [31:0] addr;
        logic [1:0]  ifc;
        logic [31:0] stamp;
    } t_entry;

    // per-cell control
    typedef struct packed {
        logic shift;      // rotate toward cell 0
        logic compact;    // odd-even squeeze of invalid holes
        logic pair_left;  // this cell is the lower member of its pair
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- rtl/core/parp_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// parp_cell
// One table slot. Rotates with its neighbors during a sweep and swaps a
// hole upward during compaction.
// ----------------------------------------------------------------------------
module parp_cell
    import parp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cell_ctl   i_ctl,
    input  t_entry      i_right,
    input  wire         i_left_valid,
    output t_entry      o_ent
);

    t_entry r_ent;
    t_entry n_ent;

    // next entry
    always_comb begin
        n_ent = r_ent;
        if (i_ctl.shift) begin
            n_ent = i_right;
        end else if (i_ctl.compact) begin
            if (i_ctl.pair_left) begin
                if (!r_ent.valid && i_right.valid) begin
                    n_ent = i_right;
                end
            end else if (!i_left_valid && r_ent.valid) begin
                n_ent.valid  = 1'b0;
                n_ent.wanted = 1'b0;
            end
        end
    end

    // flags reset, payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid  <= 1'b0;
            r_ent.wanted <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_ent = r_ent;

endmodule
`default_nettype wire

// ----- rtl/core/parp_head.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// parp_head
// Processing cell at the head of the ring: applies the operation to the
// entry passing by and accumulates the result.
// ----------------------------------------------------------------------------
module parp_head
    import parp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_clear,
    input  wire         i_en,
    input  t_req        i_req,
    input  wire [15:0]  i_timeout,
    input  t_entry      i_ent,
    output t_entry      o_ent,
    output t_rsp        o_rsp
);

    logic       r_hit;
    logic       r_filled;
    logic       r_found;
    logic [1:0] r_rif;
    logic [5:0] r_cnt;
    logic       n_hit;
    logic       n_filled;
    logic       n_found;
    logic [1:0] n_rif;
    logic [5:0] n_cnt;
    logic       addr_match;
    logic [31:0] age;
    logic [5:0] cnt_inc;

    assign addr_match = i_ent.valid && (i_ent.addr == i_req.ip_address);
    assign age        = i_req.now_seconds - i_ent.stamp;
    assign cnt_inc    = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 6'd1;

    // per-entry operation
    always_comb begin
        o_ent    = i_ent;
        n_hit    = r_hit;
        n_filled = r_filled;
        n_found  = r_found;
        n_rif    = r_rif;
        n_cnt    = r_cnt;
        unique case (i_req.opcode)
            OP_REFRESH: begin
                if (addr_match && (i_ent.ifc == i_req.interface_id) && !r_hit) begin
                    o_ent.stamp  = i_req.now_seconds;
                    o_ent.wanted = 1'b1;
                    n_hit        = 1'b1;
                end else if (!i_ent.valid && !r_hit && !r_filled) begin
                    o_ent.valid  = 1'b1;
                    o_ent.wanted = 1'b1;
                    o_ent.addr   = i_req.ip_address;
                    o_ent.ifc    = i_req.interface_id;
                    o_ent.stamp  = i_req.now_seconds;
                    n_filled     = 1'b1;
                end
            end
            OP_FIND: begin
                if (addr_match) begin
                    n_found = 1'b1;
                end
            end
            OP_MARK: begin
                if (addr_match && (i_ent.ifc != i_req.interface_id)) begin
                    o_ent.wanted = 1'b0;
                    n_cnt        = cnt_inc;
                end
            end
            OP_AGE: begin
                if (i_ent.valid && (!i_ent.wanted || (age > {16'd0, i_timeout}))) begin
                    o_ent.valid  = 1'b0;
                    o_ent.wanted = 1'b0;
                end
            end
            OP_LOOKUP: begin
                if (addr_match && i_ent.wanted && !r_found) begin
                    n_found = 1'b1;
                    n_rif   = i_ent.ifc;
                end
            end
            OP_COUNT: begin
                if (i_ent.valid && i_ent.wanted) begin
                    n_cnt = cnt_inc;
                end
            end
            default: begin
            end
        endcase
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hit    <= 1'b0;
            r_filled <= 1'b0;
            r_found  <= 1'b0;
            r_rif    <= 2'd0;
            r_cnt    <= 6'd0;
        end else if (i_en) begin
            r_hit    <= n_hit;
            r_filled <= n_filled;
            r_found  <= n_found;
            r_rif    <= n_rif;
            r_cnt    <= n_cnt;
        end
    end

    assign o_rsp.found           = r_found;
    assign o_rsp.route_interface = r_rif;
    assign o_rsp.entry_count     = r_cnt;
    assign o_rsp.status          = (i_req.opcode == OP_REFRESH) && !r_hit && !r_filled;

endmodule
`default_nettype wire

// ----- rtl/core/proxy_arp_route_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// proxy_arp_route_table
// Table of (address, interface, stamp, wanted) held in a ring of cells.
// ----------------------------------------------------------------------------
// Sequence: once start is taken in idle, the ring rotates once past the head cell
// (sweep); age out then adds an odd-even compaction; then the result strobe o_done.
// Throughput: a new request is taken only while idle (busy low), so each request
// finishes first; the single head cell sees one entry per cycle during a sweep.
// Reset: synchronous, clears all slots and sets the timeout to 60 s.
// The receiver cannot stall: o_done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module proxy_arp_route_table
    import parp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  t_req        i_req,
    input  wire         i_cfg_we,
    input  wire [15:0]  i_cfg_data,
    output logic        o_done,
    output t_rsp        o_rsp
);

    localparam int CntW = $clog2(TABLE_ENTRIES);

    t_state          r_state;
    t_state          n_state;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    t_req            r_req;
    logic [15:0]     r_timeout;
    logic            accept;
    logic            last;
    logic            sweep;
    logic            compact;
    t_entry          head_out;
    t_entry          cell_out [TABLE_ENTRIES];

    assign accept  = start && !busy;
    assign last    = (r_cnt == CntW'(TABLE_ENTRIES - 1));
    assign sweep   = (r_state == ST_SWEEP);
    assign compact = (r_state == ST_COMPACT);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        busy    = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = ST_SWEEP;
                    n_cnt   = '0;
                end
            end
            ST_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_cnt   = '0;
                    n_state = (r_req.opcode == OP_AGE) ? ST_COMPACT : ST_DONE;
                end
            end
            ST_COMPACT: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // head cell: sees the entry leaving cell 0
    parp_head u_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (accept),
        .i_en      (sweep),
        .i_req     (r_req),
        .i_timeout (r_timeout),
        .i_ent     (cell_out[0]),
        .o_ent     (head_out),
        .o_rsp     (o_rsp)
    );

    // ring of slot cells
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        localparam logic Parity = 1'(k % 2);
        t_cell_ctl ctl;
        t_entry    right;
        logic      left_valid;

        assign ctl.shift     = sweep;
        assign ctl.compact   = compact;
        assign ctl.pair_left = (Parity == r_cnt[0]);

        if (k == TABLE_ENTRIES - 1) begin : g_tail
            assign right = sweep ? head_out : '0;
        end else begin : g_mid
            assign right = cell_out[k + 1];
        end

        if (k == 0) begin : g_first
            assign left_valid = 1'b1;
        end else begin : g_rest
            assign left_valid = cell_out[k - 1].valid;
        end

        parp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_right      (right),
            .i_left_valid (left_valid),
            .o_ent        (cell_out[k])
        );
    end

endmodule
`default_nettype wire
